>>> rtl/pwmc_pkg.sv
// Shared types and op codes for the PWM edge window capture unit.
// No dependencies; imported by pwmc_ctrl, the top level and the testbench.
package pwmc_pkg;

	localparam logic [2:0] OP_FALL  = 3'd0;
	localparam logic [2:0] OP_RISE  = 3'd1;
	localparam logic [2:0] OP_OPEN  = 3'd2;
	localparam logic [2:0] OP_CLOSE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] OP_TAKE  = 3'd5;
	localparam logic [2:0] OP_RESET = 3'd6;

	localparam int TS_W    = 32;
	localparam int CNT6_W  = 6;
	localparam int IDX_W   = 5;
	localparam int ENTRY_W = 2 * TS_W;

	typedef struct packed {
		logic [2:0]        op;
		logic [TS_W-1:0]   timestamp;
		logic [IDX_W-1:0]  read_index;
	} evt_t;

	typedef struct packed {
		logic              window_open;
		logic              window_ready;
		logic              taken;
		logic [CNT6_W-1:0] sample_count;
		logic [TS_W-1:0]   entry_period;
		logic [TS_W-1:0]   entry_width;
		logic [TS_W-1:0]   measurements_total;
		logic [TS_W-1:0]   missed_rising_total;
	} res_t;

	// status after one transaction, handed from control to the result stage
	typedef struct packed {
		logic              window_open;
		logic              window_ready;
		logic              taken;
		logic [CNT6_W-1:0] sample_count;
		logic [TS_W-1:0]   measurements_total;
		logic [TS_W-1:0]   missed_rising_total;
		logic              entry_hit;
	} stat_t;

endpackage

>>> rtl/pwmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pwmc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/pwmc_ctrl.sv
// Capture state machine, window flags, counters and entry-clear flags.
// Uses pwmc_pkg; drives the write port of the window RAM.
module pwmc_ctrl #(
	parameter int WINDOW_DEPTH = 32,
	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  pwmc_pkg::evt_t        item,
	input  logic                  capture_en,
	output pwmc_pkg::stat_t       stat,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic [pwmc_pkg::ENTRY_W-1:0] wr_data
);

	import pwmc_pkg::*;

	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	logic                    wait_fall_q, wait_fall_nxt;
	logic [TS_W-1:0]         last_fall_q, last_fall_nxt;
	logic [TS_W-1:0]         last_rise_q, last_rise_nxt;
	logic [CW-1:0]           count_q, count_nxt;
	logic                    collecting_q, collecting_nxt;
	logic                    ready_q, ready_nxt;
	logic [TS_W-1:0]         total_q, total_nxt;
	logic [TS_W-1:0]         missed_q, missed_nxt;
	logic [WINDOW_DEPTH-1:0] clr_q, clr_nxt;
	logic [TS_W-1:0]         per;
	logic [TS_W-1:0]         wid;
	logic                    rise_ok;
	logic                    idx_ok;
	logic                    edges_on;
	logic                    taken;
	logic                    hit;
	logic                    store;

	always_comb begin
		wait_fall_nxt  = wait_fall_q;
		last_fall_nxt  = last_fall_q;
		last_rise_nxt  = last_rise_q;
		count_nxt      = count_q;
		collecting_nxt = collecting_q;
		ready_nxt      = ready_q;
		total_nxt      = total_q;
		missed_nxt     = missed_q;
		clr_nxt        = clr_q;
		taken          = 1'b0;
		hit            = 1'b0;
		store          = 1'b0;
		per            = item.timestamp - last_fall_q;
		rise_ok        = last_rise_q > last_fall_q;
		wid            = rise_ok ? (last_rise_q - last_fall_q) : per;
		idx_ok         = 9'(item.read_index) < 9'(WINDOW_DEPTH);
		edges_on       = capture_en && collecting_q;
		unique case (item.op)
			OP_FALL: begin
				if (edges_on) begin
					if (wait_fall_q && (count_q < CW'(WINDOW_DEPTH))) begin
						store                 = 1'b1;
						count_nxt             = count_q + CW'(1);
						total_nxt             = total_q + TS_W'(1);
						missed_nxt            = rise_ok ? missed_q : missed_q + TS_W'(1);
						clr_nxt[AW'(count_q)] = 1'b0;
					end
					last_fall_nxt = item.timestamp;
					wait_fall_nxt = 1'b0;
				end
			end
			OP_RISE: begin
				if (edges_on && !wait_fall_q) begin
					last_rise_nxt = item.timestamp;
					wait_fall_nxt = 1'b1;
				end
			end
			OP_OPEN: begin
				count_nxt      = '0;
				wait_fall_nxt  = 1'b0;
				last_fall_nxt  = '0;
				last_rise_nxt  = '0;
				collecting_nxt = 1'b1;
				ready_nxt      = 1'b0;
			end
			OP_CLOSE: begin
				if (collecting_q) begin
					collecting_nxt = 1'b0;
					ready_nxt      = 1'b1;
				end
			end
			OP_READ: begin
				hit = idx_ok && !clr_q[AW'(item.read_index)];
			end
			OP_TAKE: begin
				if (ready_q) begin
					ready_nxt = 1'b0;
					taken     = 1'b1;
				end
			end
			OP_RESET: begin
				clr_nxt        = '1;
				count_nxt      = '0;
				wait_fall_nxt  = 1'b0;
				last_fall_nxt  = '0;
				last_rise_nxt  = '0;
				collecting_nxt = 1'b0;
				ready_nxt      = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_fall_q  <= 1'b0;
			last_fall_q  <= '0;
			last_rise_q  <= '0;
			count_q      <= '0;
			collecting_q <= 1'b0;
			ready_q      <= 1'b0;
			total_q      <= '0;
			missed_q     <= '0;
			clr_q        <= '0;
		end else if (accept) begin
			wait_fall_q  <= wait_fall_nxt;
			last_fall_q  <= last_fall_nxt;
			last_rise_q  <= last_rise_nxt;
			count_q      <= count_nxt;
			collecting_q <= collecting_nxt;
			ready_q      <= ready_nxt;
			total_q      <= total_nxt;
			missed_q     <= missed_nxt;
			clr_q        <= clr_nxt;
		end
	end

	assign wr_en   = accept && store;
	assign wr_addr = AW'(count_q);
	assign wr_data = {per, wid};

	assign stat.window_open         = collecting_nxt;
	assign stat.window_ready        = ready_nxt;
	assign stat.taken               = taken;
	assign stat.sample_count        = CNT6_W'(count_nxt);
	assign stat.measurements_total  = total_nxt;
	assign stat.missed_rising_total = missed_nxt;
	assign stat.entry_hit           = hit;

endmodule

>>> rtl/pwm_edge_window_capture_unit.sv
// PWM edge window capture: top level with window RAM, control and result stage.
// Pipeline: two register stages, the stage-1 status register and the result register;
// a transaction waits in stage 1 while the result register holds a result not yet taken.
// Throughput: one transaction per cycle while results are taken; the window RAM has one write and one read port.
// Reset (arst_n low): window closed, counters zero, capture enabled; stored entries
// are not cleared and read back undefined until written or cleared by the reset op.
// Uses pwmc_pkg, pwmc_ctrl and pwmc_ram.
module pwm_edge_window_capture_unit #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	output logic            evt_ready,
	input  pwmc_pkg::evt_t  evt,
	output logic            res_valid,
	input  logic            res_ready,
	output pwmc_pkg::res_t  res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);

	import pwmc_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	logic               capture_en_q;
	logic               evt_accept;
	logic               s1_valid;
	logic               s1_advance;
	stat_t              stat;
	stat_t              stat_s1;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_data;
	logic               res_valid_q;
	res_t               res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			capture_en_q <= cfg_data;
		end
	end

	assign s1_advance = s1_valid && (!res_valid_q || res_ready);
	assign evt_ready  = !s1_valid || s1_advance;
	assign evt_accept = evt_valid && evt_ready;

	pwmc_ctrl #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (evt_accept),
		.item      (evt),
		.capture_en(capture_en_q),
		.stat      (stat),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	assign rd_en = evt_accept && (evt.op == OP_READ);

	pwmc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(AW'(evt.read_index)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (evt_ready) begin
			s1_valid <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_accept) begin
			stat_s1 <= stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			res_q.window_open         <= stat_s1.window_open;
			res_q.window_ready        <= stat_s1.window_ready;
			res_q.taken               <= stat_s1.taken;
			res_q.sample_count        <= stat_s1.sample_count;
			res_q.entry_period        <= stat_s1.entry_hit ? rd_data[ENTRY_W-1:TS_W] : '0;
			res_q.entry_width         <= stat_s1.entry_hit ? rd_data[TS_W-1:0] : '0;
			res_q.measurements_total  <= stat_s1.measurements_total;
			res_q.missed_rising_total <= stat_s1.missed_rising_total;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_open_clears: assert property (@(posedge clk) disable iff (!arst_n)
		evt_accept && (evt.op == OP_OPEN) |=> stat_s1.window_open
			&& !stat_s1.window_ready && (stat_s1.sample_count == '0))
		else $error("open did not start an empty window");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> !(stat_s1.window_open && stat_s1.window_ready))
		else $error("window open and ready together");

	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && stat_s1.taken |-> !stat_s1.window_ready)
		else $error("take left the window ready");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && res_valid_q && !res_ready |-> !evt_ready)
		else $error("transaction accepted while pipeline stalled");

endmodule

>>> dv/tb_top.sv
// Testbench for pwm_edge_window_capture_unit: directed and random edge/window traffic
// checked against a scoreboard that models the capture machine and window store.
// Depends on rtl/pwmc_pkg.sv and rtl/pwm_edge_window_capture_unit.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pwmc_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int NUM_PHASES = 6;

	class capture_scoreboard;
		bit        capture_on;
		bit        wait_fall;
		bit [31:0] fall_t;
		bit [31:0] rise_t;
		int        entries;
		bit        collecting;
		bit        win_ready;
		bit [31:0] period_mem [DEPTH];
		bit [31:0] width_mem [DEPTH];
		bit        written [DEPTH];
		bit [31:0] total;
		bit [31:0] missed;
		res_t      expected_q [$];
		int        errors;
		int        printed;

		function new();
			capture_on = 1'b1;
			entries = 0;
			errors = 0;
			printed = 0;
		endfunction

		function void clear_capture();
			wait_fall = 1'b0;
			fall_t = '0;
			rise_t = '0;
		endfunction

		// returns 0 for an edge while capture is off or no window is collecting, and for an unused op code
		function bit note_event(evt_t e);
			res_t      want;
			bit        edges_on;
			bit        effective;
			bit [31:0] per;
			edges_on = capture_on && collecting;
			effective = 1'b1;
			want = '0;
			case (e.op)
				OP_FALL: begin
					if (edges_on) begin
						if (wait_fall && entries < DEPTH) begin
							per = e.timestamp - fall_t;
							period_mem[entries] = per;
							if (rise_t > fall_t) begin
								width_mem[entries] = rise_t - fall_t;
							end else begin
								width_mem[entries] = per;
								missed++;
							end
							written[entries] = 1'b1;
							entries++;
							total++;
						end
						fall_t = e.timestamp;
						wait_fall = 1'b0;
					end else begin
						effective = 1'b0;
					end
				end
				OP_RISE: begin
					if (edges_on) begin
						if (!wait_fall) begin
							rise_t = e.timestamp;
							wait_fall = 1'b1;
						end
					end else begin
						effective = 1'b0;
					end
				end
				OP_OPEN: begin
					entries = 0;
					clear_capture();
					collecting = 1'b1;
					win_ready = 1'b0;
				end
				OP_CLOSE: begin
					if (collecting) begin
						collecting = 1'b0;
						win_ready = 1'b1;
					end
				end
				OP_READ: begin
					want.entry_period = period_mem[e.read_index];
					want.entry_width = width_mem[e.read_index];
				end
				OP_TAKE: begin
					if (win_ready) begin
						win_ready = 1'b0;
						want.taken = 1'b1;
					end
				end
				OP_RESET: begin
					for (int i = 0; i < DEPTH; i++) begin
						period_mem[i] = '0;
						width_mem[i] = '0;
						written[i] = 1'b1;
					end
					entries = 0;
					clear_capture();
					win_ready = 1'b0;
					collecting = 1'b0;
				end
				default: effective = 1'b0;
			endcase
			want.window_open = collecting;
			want.window_ready = win_ready;
			want.sample_count = entries[5:0];
			want.measurements_total = total;
			want.missed_rising_total = missed;
			expected_q.push_back(want);
			return effective;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (printed < 100) begin
				$display("MISMATCH %s: got %0h expected %0h", what, got, want);
				printed++;
			end
		endtask

		task check_result(res_t r);
			res_t w;
			if (expected_q.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			w = expected_q.pop_front();
			if (r.window_open !== w.window_open)
				report("window_open", r.window_open, w.window_open);
			if (r.window_ready !== w.window_ready)
				report("window_ready", r.window_ready, w.window_ready);
			if (r.taken !== w.taken)
				report("taken", r.taken, w.taken);
			if (r.sample_count !== w.sample_count)
				report("sample_count", r.sample_count, w.sample_count);
			if (r.entry_period !== w.entry_period)
				report("entry_period", r.entry_period, w.entry_period);
			if (r.entry_width !== w.entry_width)
				report("entry_width", r.entry_width, w.entry_width);
			if (r.measurements_total !== w.measurements_total)
				report("measurements_total", r.measurements_total, w.measurements_total);
			if (r.missed_rising_total !== w.missed_rising_total)
				report("missed_rising_total", r.missed_rising_total, w.missed_rising_total);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	evt_t evt = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	capture_scoreboard sb = new();
	int tx_idle = 19;
	int rx_idle = 45;
	int counted = 0;
	int stall_cycles = 0;
	logic [31:0] ts_now = 32'd1000;

	pwm_edge_window_capture_unit #(.WINDOW_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res);
		res_ready <= ($urandom_range(99, 0) >= rx_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (evt_valid && evt_ready) || (res_valid && res_ready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_evt(evt_t e);
		while ($urandom_range(99, 0) < tx_idle) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		@(posedge clk);
		while (!evt_ready)
			@(posedge clk);
		void'(sb.note_event(e));
		counted++;
	endtask

	// reads are steered away from entries never written since reset
	task automatic send_op(logic [2:0] op, logic [31:0] ts, logic [4:0] idx);
		evt_t e;
		int   start;
		bit   found;
		if (op == OP_READ && !sb.written[idx]) begin
			found = 1'b0;
			start = $urandom_range(DEPTH - 1, 0);
			for (int i = 0; i < DEPTH; i++) begin
				if (!found && sb.written[(start + i) % DEPTH]) begin
					idx = 5'((start + i) % DEPTH);
					found = 1'b1;
				end
			end
			if (!found)
				op = OP_TAKE;
		end
		e.op = op;
		e.timestamp = ts;
		e.read_index = idx;
		send_evt(e);
	endtask

	task automatic drain();
		evt_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	task automatic write_capture(bit v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.capture_on = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [4:0] pick_index();
		if (sb.entries > 0 && $urandom_range(99, 0) < 70)
			return 5'($urandom_range(sb.entries - 1, 0));
		return 5'($urandom_range(DEPTH - 1, 0));
	endfunction

	task automatic send_noise();
		send_op(3'($urandom_range(7, 0)), $urandom, 5'($urandom_range(31, 0)));
	endtask

	// open, a train of pulses, close, read back and take; open or close may be skipped, a reset may follow
	task automatic gen_window();
		int          n;
		logic [31:0] w;
		logic [31:0] p;
		logic [31:0] t;
		if ($urandom_range(99, 0) < 90)
			send_op(OP_OPEN, $urandom, 5'($urandom_range(31, 0)));
		case ($urandom_range(9, 0))
			7, 8: n = $urandom_range(40, 28);
			9: n = $urandom_range(2, 0);
			default: n = $urandom_range(12, 0);
		endcase
		if ($urandom_range(9, 0) == 0)
			ts_now = 32'hFFFF_FFFF - $urandom_range(3000, 0);
		t = ts_now;
		send_op(OP_FALL, t, 5'($urandom_range(31, 0)));
		repeat (n) begin
			w = ($urandom_range(9, 0) == 0) ? 32'd0 : $urandom_range(1000, 1);
			p = w + $urandom_range(1000, 1);
			if ($urandom_range(99, 0) < 80) begin
				send_op(OP_RISE, t + w, 5'($urandom_range(31, 0)));
				if ($urandom_range(99, 0) < 5)
					send_op(OP_RISE, t + w + 32'd1, 5'($urandom_range(31, 0)));
			end
			if ($urandom_range(99, 0) < 4)
				send_noise();
			t = t + p;
			send_op(OP_FALL, t, 5'($urandom_range(31, 0)));
		end
		ts_now = t + $urandom_range(5000, 1);
		if ($urandom_range(99, 0) < 92)
			send_op(OP_CLOSE, $urandom, 5'($urandom_range(31, 0)));
		repeat ($urandom_range(4, 0))
			send_op(OP_READ, $urandom, pick_index());
		send_op(OP_TAKE, $urandom, 5'($urandom_range(31, 0)));
		if ($urandom_range(99, 0) < 30)
			send_op(OP_TAKE, $urandom, 5'($urandom_range(31, 0)));
		if ($urandom_range(99, 0) < 10)
			send_op(OP_CLOSE, $urandom, 5'($urandom_range(31, 0)));
		if ($urandom_range(99, 0) < 8)
			send_op(OP_RESET, $urandom, 5'($urandom_range(31, 0)));
	endtask

	initial begin
		bit en;
		int quota;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// commands with no window, then a short capture with wrap and missed rising, then a window with capture off
		send_op(OP_TAKE, 32'd0, 5'd0);
		send_op(OP_CLOSE, 32'd0, 5'd0);
		send_op(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
		send_op(OP_FALL, 32'd123, 5'd0);
		send_op(OP_RESET, 32'd0, 5'd0);
		send_op(OP_READ, 32'd0, 5'd0);
		send_op(OP_READ, 32'hFFFF_FFFF, 5'd31);
		send_op(OP_OPEN, 32'd0, 5'd0);
		send_op(OP_FALL, 32'd0, 5'd0);
		send_op(OP_FALL, 32'd100, 5'd0);
		send_op(OP_RISE, 32'd130, 5'd0);
		send_op(OP_RISE, 32'd140, 5'd0);
		send_op(OP_FALL, 32'd200, 5'd0);
		send_op(OP_RISE, 32'hFFFF_FFF0, 5'd0);
		send_op(OP_FALL, 32'hFFFF_FFFF, 5'd0);
		send_op(OP_RISE, 32'd5, 5'd0);
		send_op(OP_FALL, 32'd1000, 5'd0);
		send_op(OP_CLOSE, 32'd0, 5'd0);
		send_op(OP_READ, 32'd0, 5'd2);
		send_op(OP_READ, 32'd0, 5'd1);
		send_op(OP_TAKE, 32'd0, 5'd0);
		send_op(OP_TAKE, 32'd0, 5'd0);
		drain();
		write_capture(1'b0);
		send_op(OP_OPEN, 32'd0, 5'd0);
		send_op(OP_FALL, 32'd10, 5'd0);
		send_op(OP_RISE, 32'd20, 5'd0);
		send_op(OP_FALL, 32'd30, 5'd0);
		send_op(OP_CLOSE, 32'd0, 5'd0);
		drain();
		write_capture(1'b1);

		for (int k = 0; k < NUM_PHASES; k++) begin
			case (k / 2)
				0: begin tx_idle = 19; rx_idle = 45; end
				1: begin tx_idle = 45; rx_idle = 19; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			en = !(k == 1 || k == 4);
			quota = en ? 420 : 40;
			drain();
			write_capture(en);
			counted = 0;
			while (counted < quota) begin
				if ($urandom_range(99, 0) < 15)
					repeat ($urandom_range(5, 1)) send_noise();
				else
					gen_window();
			end
		end

		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report("results missing", sb.expected_q.size(), 0);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

>>> sim.f
rtl/pwmc_pkg.sv
rtl/pwmc_ram.sv
rtl/pwmc_ctrl.sv
rtl/pwm_edge_window_capture_unit.sv
dv/tb_top.sv
